[hw/rtl/fftc_pkg.sv]
// Package with shared constants, types and twiddle table for the FFT convolution block.
`timescale 1ns / 1ps
package fftc_pkg;
  localparam int MAX_N_DEF = 64;
  localparam int TWIDDLE_FRAC_DEF = 15;
  localparam int WW = 48;

  typedef struct packed {
    logic        mode;
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
  } in_word_t;

  function automatic logic signed [25:0] qcos(input logic [4:0] r, input int frac);
    logic signed [25:0] q;
    int d;
    begin
      case (r)
        5'd0: q = 26'sd16777216;
        5'd1: q = 26'sd16696429;
        5'd2: q = 26'sd16454846;
        5'd3: q = 26'sd16054795;
        5'd4: q = 26'sd15500126;
        5'd5: q = 26'sd14796184;
        5'd6: q = 26'sd13949745;
        5'd7: q = 26'sd12968963;
        5'd8: q = 26'sd11863283;
        5'd9: q = 26'sd10643353;
        5'd10: q = 26'sd9320922;
        5'd11: q = 26'sd7908725;
        5'd12: q = 26'sd6420363;
        5'd13: q = 26'sd4870169;
        5'd14: q = 26'sd3273072;
        5'd15: q = 26'sd1644455;
        default: q = 26'sd0;
      endcase
      d = 24 - frac;
      if (d > 0) begin
        q = (q + (26'sd1 <<< (d - 1))) >>> d;
      end
      qcos = q;
    end
  endfunction

  function automatic logic signed [WW-1:0] sat48(input logic signed [WW+1:0] x);
    logic signed [WW+1:0] hi;
    logic signed [WW+1:0] lo;
    begin
      hi = (50'sd1 <<< (WW - 1)) - 50'sd1;
      lo = -hi - 50'sd1;
      if (x > hi) sat48 = hi[WW-1:0];
      else if (x < lo) sat48 = lo[WW-1:0];
      else sat48 = x[WW-1:0];
    end
  endfunction

  function automatic logic signed [30:0] sat31(input logic signed [WW-1:0] x);
    begin
      if (x > 48'sd1073741823) sat31 = 31'sd1073741823;
      else if (x < -48'sd1073741824) sat31 = -31'sd1073741824;
      else sat31 = x[30:0];
    end
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [WW-1:0] x);
    begin
      if (x > 48'sd549755813887) sat40 = 40'sd549755813887;
      else if (x < -48'sd549755813888) sat40 = -40'sd549755813888;
      else sat40 = x[39:0];
    end
  endfunction
endpackage

[hw/rtl/fft_convolution.sv]
// Top level of the FFT polynomial convolution block.
`timescale 1ns / 1ps
// Usage: input words (mode, re, im, last) are pushed while full is low; mode
// selects sequence a or b. A word of b with last set starts a run. Results
// appear as a queue: while empty is low, index, res_re, res_im, too_long and
// end_res hold the oldest result, and pop takes it. n results come per run,
// end_res marks the last one.
// Flow: a small input queue takes words at one per cycle while the engine is
// loading. The run pads the stores, then runs two forward and one inverse
// transform on one butterfly unit, n/2*log2(n) butterflies each; a butterfly
// steps through read, multiply, add and write states, and the product reads,
// multiplies and writes each point. Each result is read in S_ORD, then shown.
// Reset clears the counts, the input queue and the engine state; stored data
// is overwritten by the padding pass of the next run. While the receiver does
// not pop, the engine holds the current result and the queue fills up.
module fft_convolution #(
  parameter int MAX_N = fftc_pkg::MAX_N_DEF,
  parameter int TWIDDLE_FRAC = fftc_pkg::TWIDDLE_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               mode,
  input  logic signed [15:0] re,
  input  logic signed [15:0] im,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         index,
  output logic signed [39:0] res_re,
  output logic signed [39:0] res_im,
  output logic               too_long,
  output logic               end_res
);
  import fftc_pkg::*;
  in_word_t din, qout;
  logic     q_empty, q_pop;
  assign din = '{mode: mode, re: re, im: im, last: last};

  fftc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full),
    .pop(q_pop), .dout(qout), .empty(q_empty)
  );

  fftc_engine #(.MAX_N(MAX_N), .TWIDDLE_FRAC(TWIDDLE_FRAC)) u_engine (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_word(qout), .q_pop(q_pop),
    .empty(empty), .pop(pop), .index(index), .res_re(res_re), .res_im(res_im),
    .too_long(too_long), .end_res(end_res)
  );
endmodule

[hw/rtl/fftc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/fftc_queue.sv]
// Short queue of input words between the front and the compute engine.
`timescale 1ns / 1ps
module fftc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fftc_pkg::in_word_t din,
  output logic              full,
  input  logic              pop,
  output fftc_pkg::in_word_t dout,
  output logic              empty
);
  import fftc_pkg::*;
  in_word_t    slot [4];
  logic [1:0]  wp;
  logic [1:0]  rp;
  logic [2:0]  cnt;
  assign full = (cnt == 3'd4);
  assign empty = (cnt == 3'd0);
  assign dout = slot[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        slot[wp] <= din;
        wp <= wp + 2'd1;
      end
      if (pop && !empty) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push && !full) - 3'(pop && !empty);
    end
  end
endmodule

[hw/rtl/fftc_engine.sv]
// Compute engine: loads words, runs the transforms with one butterfly, emits results.
`timescale 1ns / 1ps
module fftc_engine #(
  parameter int MAX_N = fftc_pkg::MAX_N_DEF,
  parameter int TWIDDLE_FRAC = fftc_pkg::TWIDDLE_FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  fftc_pkg::in_word_t q_word,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         index,
  output logic signed [39:0] res_re,
  output logic signed [39:0] res_im,
  output logic               too_long,
  output logic               end_res
);
  import fftc_pkg::*;
  localparam int CAP = (MAX_N >= 64) ? 64 : (1 << ($clog2(MAX_N + 1) - 1));
  localparam int AW = 6;
  localparam int CW = 7;

  typedef enum logic [3:0] {
    S_LOAD, S_PAD, S_PASS, S_RD0, S_RD1, S_MUL, S_MUL2, S_ADD, S_WR0, S_WR1, S_PRD, S_PMUL,
    S_PWR, S_ORD, S_OUT
  } state_t;
  state_t state;

  // Storage: array 0 = a, array 1 = b; separate re and im.
  logic          we [4];
  logic [AW-1:0] wa [4];
  logic [WW-1:0] wd [4];
  logic [AW-1:0] ra [4];
  logic [WW-1:0] rd [4];
  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_mem
      fftc_ram #(.WIDTH(WW), .DEPTH(64)) u_ram (
        .clk(clk), .we(we[g]), .waddr(wa[g]), .wdata(wd[g]), .raddr(ra[g]), .rdata(rd[g])
      );
    end
  endgenerate

  logic [CW-1:0] count_a, count_b;
  logic          overflow_seen;
  logic [2:0]    lg;
  logic [1:0]    pass;        // 0 fwd a, 1 fwd b, 2 product, 3 inverse
  logic          sel;          // working array
  logic [CW-1:0] ctr;          // pad / index counter
  logic [2:0]    stg;
  logic [4:0]    bf;           // butterfly index within stage
  logic signed [WW-1:0] ur, ui, yr, yi;
  logic signed [25:0] tc, ts;
  logic signed [95:0] p0, p1, p2, p3;
  logic signed [WW-1:0] vr, vi;

  logic [CW-1:0] n;
  assign n = CW'(1) << lg;

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] i, input logic [2:0] l);
    logic [AW-1:0] r;
    begin
      r = '0;
      for (int b = 0; b < AW; b++) begin
        if (b < l) r[l - 1 - b] = i[b];
      end
      bitrev = r;
    end
  endfunction

  // Butterfly addresses in natural-order DIT with bit-reversed input read.
  logic [AW-1:0] half_m, jj, stt, bx, by;
  logic [5:0]    kk;
  always_comb begin
    half_m = AW'(1) << stg;
    jj = AW'(bf) & (half_m - AW'(1));
    stt = (AW'(bf) >> stg) << (stg + 3'd1);
    bx = stt + jj;
    by = bx + half_m;
    kk = 6'(jj << (3'd5 - stg));
  end

  // The forward transforms address logical position x at bitrev(x), which applies the
  // input permutation in place and leaves each spectrum in bit-reversed order. The
  // product keeps that order, so the inverse addresses naturally and ends in natural order.
  logic [AW-1:0] px, py;
  assign px = (pass == 2'd3) ? bx : bitrev(bx, lg);
  assign py = (pass == 2'd3) ? by : bitrev(by, lg);

  logic signed [25:0] cr, sr;
  always_comb begin
    cr = qcos({1'b0, kk[3:0]}, TWIDDLE_FRAC);
    sr = qcos(5'd16 - {1'b0, kk[3:0]}, TWIDDLE_FRAC);
  end

  // The twiddle product is formed in S_MUL from the low 24 bits of the operand, then in S_MUL2 from the high part.
  logic signed [24:0] mop_r, mop_i;
  logic signed [50:0] m0, m1, m2, m3;
  always_comb begin
    if (state == S_MUL) begin
      mop_r = signed'({1'b0, rd[{sel, 1'b0}][23:0]});
      mop_i = signed'({1'b0, rd[{sel, 1'b1}][23:0]});
    end else begin
      mop_r = signed'({yr[WW-1], yr[WW-1:24]});
      mop_i = signed'({yi[WW-1], yi[WW-1:24]});
    end
    m0 = mop_r * tc;
    m1 = mop_i * ts;
    m2 = mop_i * tc;
    m3 = mop_r * ts;
  end

  logic signed [WW+1:0] s0r, s0i, s1r, s1i;
  always_comb begin
    s0r = {{2{ur[WW-1]}}, ur} + {{2{vr[WW-1]}}, vr};
    s0i = {{2{ui[WW-1]}}, ui} + {{2{vi[WW-1]}}, vi};
    s1r = {{2{ur[WW-1]}}, ur} - {{2{vr[WW-1]}}, vr};
    s1i = {{2{ui[WW-1]}}, ui} - {{2{vi[WW-1]}}, vi};
    if (pass == 2'd3) begin
      s0r = (s0r + 50'sd1) >>> 1;
      s0i = (s0i + 50'sd1) >>> 1;
      s1r = (s1r + 50'sd1) >>> 1;
      s1i = (s1i + 50'sd1) >>> 1;
    end
  end

  logic signed [30:0] ar, ai, br, bi;
  always_comb begin
    ar = sat31(rd[0]);
    ai = sat31(rd[1]);
    br = sat31(rd[2]);
    bi = sat31(rd[3]);
  end

  logic signed [WW+1:0] prr, pri;
  always_comb begin
    prr = 50'(p0 - p1);
    pri = 50'(p2 + p3);
  end

  logic [2:0] lg_calc;
  always_comb begin
    lg_calc = 3'd6;
    for (int k = 6; k >= 1; k--) begin
      if ((count_a + count_b) <= (CW'(1) << (k - 1))) lg_calc = 3'(k - 1);
    end
  end

  assign q_pop = (state == S_LOAD) && !q_empty;
  assign empty = (state != S_OUT);
  assign index = 6'(ctr);
  assign too_long = overflow_seen;
  assign end_res = (ctr == n - CW'(1));
  assign res_re = sat40(rd[0]);
  assign res_im = sat40(rd[1]);

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      we[m] = 1'b0;
      wa[m] = '0;
      wd[m] = '0;
      ra[m] = '0;
    end
    unique case (state)
      S_LOAD: begin
        if (!q_empty && (count_a + count_b) < CW'(CAP)) begin
          if (!q_word.mode) begin
            we[0] = 1'b1; we[1] = 1'b1;
            wa[0] = AW'(count_a); wa[1] = AW'(count_a);
          end else begin
            we[2] = 1'b1; we[3] = 1'b1;
            wa[2] = AW'(count_b); wa[3] = AW'(count_b);
          end
          wd[0] = WW'(signed'(q_word.re)); wd[1] = WW'(signed'(q_word.im));
          wd[2] = WW'(signed'(q_word.re)); wd[3] = WW'(signed'(q_word.im));
        end
      end
      S_PAD: begin
        if (ctr >= count_a) begin
          we[0] = 1'b1; we[1] = 1'b1;
        end
        if (ctr >= count_b) begin
          we[2] = 1'b1; we[3] = 1'b1;
        end
        for (int m = 0; m < 4; m++) wa[m] = AW'(ctr);
      end
      S_RD0: begin
        ra[{sel, 1'b0}] = px; ra[{sel, 1'b1}] = px;
      end
      S_RD1: begin
        ra[{sel, 1'b0}] = py; ra[{sel, 1'b1}] = py;
      end
      S_WR0: begin
        we[{sel, 1'b0}] = 1'b1; we[{sel, 1'b1}] = 1'b1;
        wa[{sel, 1'b0}] = px; wa[{sel, 1'b1}] = px;
        wd[{sel, 1'b0}] = sat48(s0r); wd[{sel, 1'b1}] = sat48(s0i);
      end
      S_WR1: begin
        we[{sel, 1'b0}] = 1'b1; we[{sel, 1'b1}] = 1'b1;
        wa[{sel, 1'b0}] = py; wa[{sel, 1'b1}] = py;
        wd[{sel, 1'b0}] = sat48(s1r); wd[{sel, 1'b1}] = sat48(s1i);
      end
      S_PRD: begin
        for (int m = 0; m < 4; m++) ra[m] = AW'(ctr);
      end
      S_PWR: begin
        we[0] = 1'b1; we[1] = 1'b1;
        wa[0] = AW'(ctr); wa[1] = AW'(ctr);
        wd[0] = sat48(prr); wd[1] = sat48(pri);
      end
      S_ORD, S_OUT: begin
        ra[0] = AW'((n - ctr) & (n - CW'(1)));
        ra[1] = ra[0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count_a <= '0;
      count_b <= '0;
      overflow_seen <= 1'b0;
      ctr <= '0;
      pass <= '0;
      sel <= 1'b0;
      stg <= '0;
      bf <= '0;
      lg <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (!q_empty) begin
            if ((count_a + count_b) < CW'(CAP)) begin
              if (!q_word.mode) count_a <= count_a + CW'(1);
              else count_b <= count_b + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (q_word.mode && q_word.last) begin
              state <= S_PAD;
              ctr <= '0;
            end
          end
        end
        S_PAD: begin
          lg <= lg_calc;
          if (ctr == CW'(63)) begin
            state <= S_PASS;
            pass <= 2'd0;
            sel <= 1'b0;
          end else begin
            ctr <= ctr + CW'(1);
          end
        end
        S_PASS: begin
          stg <= '0;
          bf <= '0;
          ctr <= '0;
          if (lg == 3'd0 && pass != 2'd2) begin
            if (pass == 2'd3) begin
              state <= S_ORD;
            end else begin
              pass <= pass + 2'd1;
              sel <= (pass == 2'd0);
              if (pass == 2'd1) state <= S_PRD;
            end
          end else if (pass == 2'd2) begin
            state <= S_PRD;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          ur <= rd[{sel, 1'b0}];
          ui <= rd[{sel, 1'b1}];
          case (kk[5:4])
            2'd0: begin tc <= cr; ts <= sr; end
            2'd1: begin tc <= -sr; ts <= cr; end
            2'd2: begin tc <= -cr; ts <= -sr; end
            default: begin tc <= sr; ts <= -cr; end
          endcase
          state <= S_MUL;
        end
        S_MUL: begin
          yr <= rd[{sel, 1'b0}];
          yi <= rd[{sel, 1'b1}];
          p0 <= 96'(m0);
          p1 <= 96'(m1);
          p2 <= 96'(m2);
          p3 <= 96'(m3);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p0 <= p0 + (96'(m0) <<< 24);
          p1 <= p1 + (96'(m1) <<< 24);
          p2 <= p2 + (96'(m2) <<< 24);
          p3 <= p3 + (96'(m3) <<< 24);
          state <= S_ADD;
        end
        S_ADD: begin
          vr <= WW'((p0 - p1 + (96'sd1 <<< (TWIDDLE_FRAC - 1))) >>> TWIDDLE_FRAC);
          vi <= WW'((p2 + p3 + (96'sd1 <<< (TWIDDLE_FRAC - 1))) >>> TWIDDLE_FRAC);
          state <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          if (6'(bf) == 6'(n >> 1) - 6'd1) begin
            bf <= '0;
            if (stg == lg - 3'd1) begin
              if (pass == 2'd3) begin
                ctr <= '0;
                state <= S_ORD;
              end else begin
                state <= S_PASS;
                pass <= pass + 2'd1;
                sel <= (pass == 2'd0);
              end
            end else begin
              stg <= stg + 3'd1;
              state <= S_RD0;
            end
          end else begin
            bf <= bf + 5'd1;
            state <= S_RD0;
          end
        end
        S_PRD: begin
          sel <= 1'b0;
          state <= S_PMUL;
        end
        S_PMUL: begin
          p0 <= 96'(ar) * 96'(br);
          p1 <= 96'(ai) * 96'(bi);
          p2 <= 96'(ar) * 96'(bi);
          p3 <= 96'(ai) * 96'(br);
          state <= S_PWR;
        end
        S_PWR: begin
          if (ctr == n - CW'(1)) begin
            ctr <= '0;
            pass <= 2'd3;
            state <= S_PASS;
          end else begin
            ctr <= ctr + CW'(1);
            state <= S_PRD;
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (pop) begin
            if (ctr == n - CW'(1)) begin
              count_a <= '0;
              count_b <= '0;
              overflow_seen <= 1'b0;
              ctr <= '0;
              pass <= 2'd0;
              lg <= '0;
              state <= S_LOAD;
            end else begin
              ctr <= ctr + CW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

[tb/tb_top.sv]
// Testbench for fft_convolution: random and directed sequences checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import fftc_pkg::*;

  typedef struct {
    logic [5:0]         index;
    logic signed [39:0] res_re;
    logic signed [39:0] res_im;
    logic               too_long;
    logic               end_res;
  } conv_res_t;

  localparam longint QUARTER_COS[17] = '{
    16777216, 16696429, 16454846, 16054795, 15500126, 14796184, 13949745,
    12968963, 11863283, 10643353, 9320922, 7908725, 6420363, 4870169,
    3273072, 1644455, 0
  };
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic mode = 1'b0;
  logic signed [15:0] re = '0;
  logic signed [15:0] im = '0;
  logic last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [5:0] index;
  logic signed [39:0] res_re;
  logic signed [39:0] res_im;
  logic too_long;
  logic end_res;

  in_word_t pending_words[$];
  conv_res_t expected_conv[$];
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int idle_cycles = 0;

  longint seq_a_re[64], seq_a_im[64], seq_b_re[64], seq_b_im[64];
  longint xf_re[64], xf_im[64];
  int len_a = 0;
  int len_b = 0;
  bit dropped = 1'b0;

  always #1 clk = ~clk;

  fft_convolution dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .re(re), .im(im),
    .last(last), .empty(empty), .pop(pop), .index(index), .res_re(res_re),
    .res_im(res_im), .too_long(too_long), .end_res(end_res)
  );

  function automatic longint clamp_bits(longint x, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic void twiddle_at(int k, output longint c, output longint s);
    longint cr;
    longint sr;
    cr = (QUARTER_COS[k & 15] + 256) >>> 9;
    sr = (QUARTER_COS[16 - (k & 15)] + 256) >>> 9;
    case ((k >> 4) & 3)
      0: begin c = cr; s = sr; end
      1: begin c = -sr; s = cr; end
      2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endfunction

  function automatic longint rotate(longint a, longint b, longint c, longint s);
    logic signed [95:0] t;
    t = 96'(a) * 96'(c) - 96'(b) * 96'(s) + 96'sd16384;
    t = t >>> 15;
    return longint'(t);
  endfunction

  function automatic void butterfly_pass(int lg, bit halve);
    int n;
    int r;
    int half;
    int x;
    int y;
    longint t;
    longint c;
    longint s;
    longint vr;
    longint vi;
    longint s0r;
    longint s0i;
    longint s1r;
    longint s1i;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (r > i) begin
        t = xf_re[i]; xf_re[i] = xf_re[r]; xf_re[r] = t;
        t = xf_im[i]; xf_im[i] = xf_im[r]; xf_im[r] = t;
      end
    end
    for (int len = 2; len <= n; len <<= 1) begin
      half = len >> 1;
      for (int st = 0; st < n; st += len) begin
        for (int j = 0; j < half; j++) begin
          x = st + j;
          y = st + j + half;
          twiddle_at(j * (64 / len), c, s);
          vr = rotate(xf_re[y], xf_im[y], c, s);
          vi = rotate(xf_im[y], xf_re[y], c, -s);
          s0r = xf_re[x] + vr; s0i = xf_im[x] + vi;
          s1r = xf_re[x] - vr; s1i = xf_im[x] - vi;
          if (halve) begin
            s0r = (s0r + 1) >>> 1; s0i = (s0i + 1) >>> 1;
            s1r = (s1r + 1) >>> 1; s1i = (s1i + 1) >>> 1;
          end
          xf_re[x] = clamp_bits(s0r, 48); xf_im[x] = clamp_bits(s0i, 48);
          xf_re[y] = clamp_bits(s1r, 48); xf_im[y] = clamp_bits(s1i, 48);
        end
      end
    end
  endfunction

  function automatic void convolve_word(logic m, logic signed [15:0] wr,
                                        logic signed [15:0] wi, logic lst);
    int n;
    int lg;
    longint pr[64];
    longint pi[64];
    longint ar;
    longint ai;
    longint br;
    longint bi;
    conv_res_t res;
    if (len_a + len_b < 64) begin
      if (m == 1'b0) begin
        seq_a_re[len_a] = wr; seq_a_im[len_a] = wi; len_a++;
      end else begin
        seq_b_re[len_b] = wr; seq_b_im[len_b] = wi; len_b++;
      end
    end else begin
      dropped = 1'b1;
    end
    if (!(m && lst)) return;
    n = 1;
    lg = 0;
    while (n < len_a + len_b) begin n <<= 1; lg++; end
    for (int i = 0; i < n; i++) begin
      xf_re[i] = i < len_b ? seq_b_re[i] : 0;
      xf_im[i] = i < len_b ? seq_b_im[i] : 0;
    end
    butterfly_pass(lg, 1'b0);
    for (int i = 0; i < n; i++) begin pr[i] = xf_re[i]; pi[i] = xf_im[i]; end
    for (int i = 0; i < n; i++) begin
      xf_re[i] = i < len_a ? seq_a_re[i] : 0;
      xf_im[i] = i < len_a ? seq_a_im[i] : 0;
    end
    butterfly_pass(lg, 1'b0);
    for (int i = 0; i < n; i++) begin
      ar = clamp_bits(xf_re[i], 31); ai = clamp_bits(xf_im[i], 31);
      br = clamp_bits(pr[i], 31); bi = clamp_bits(pi[i], 31);
      xf_re[i] = clamp_bits(ar * br - ai * bi, 48);
      xf_im[i] = clamp_bits(ar * bi + ai * br, 48);
    end
    butterfly_pass(lg, 1'b1);
    for (int i = 0; i < n; i++) begin
      res.index = 6'(i);
      res.res_re = 40'(clamp_bits(xf_re[(n - i) & (n - 1)], 40));
      res.res_im = 40'(clamp_bits(xf_im[(n - i) & (n - 1)], 40));
      res.too_long = dropped;
      res.end_res = (i == n - 1);
      expected_conv.push_back(res);
    end
    len_a = 0;
    len_b = 0;
    dropped = 1'b0;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_word(logic m, logic [15:0] wr, logic [15:0] wi, logic lst);
    in_word_t w;
    w.mode = m; w.re = wr; w.im = wi; w.last = lst;
    pending_words.push_back(w);
  endfunction

  // One run: na words of a and nb words of b in random order, the final b word last.
  function automatic void add_run(int na, int nb);
    int left_a;
    int left_b;
    left_a = na;
    left_b = nb - 1;
    while (left_a + left_b > 0) begin
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
        add_word(1'b0, rand_value(), rand_value(), left_a == 1 ? 1'($urandom) : 1'b0);
        left_a--;
      end else begin
        add_word(1'b1, rand_value(), rand_value(), 1'b0);
        left_b--;
      end
    end
    add_word(1'b1, rand_value(), rand_value(), 1'b1);
  endfunction

  initial begin
    int na;
    add_word(1'b0, 16'h7fff, 16'h8000, 1'b0);
    add_word(1'b0, 16'h8000, 16'h7fff, 1'b1);
    add_word(1'b1, 16'h8000, 16'h8000, 1'b0);
    add_word(1'b1, 16'h7fff, 16'h7fff, 1'b1);
    add_word(1'b1, 16'h0000, 16'hffff, 1'b1);
    add_word(1'b1, 16'h0001, 16'h0000, 1'b0);
    add_word(1'b0, 16'h0003, 16'hfffe, 1'b0);
    add_word(1'b1, 16'hffff, 16'h0002, 1'b0);
    add_word(1'b0, 16'h8000, 16'h0000, 1'b0);
    add_word(1'b1, 16'h0000, 16'h7fff, 1'b1);
    add_run(40, 24);
    add_word(1'b0, 16'h1234, 16'h5678, 1'b1);
    add_word(1'b1, 16'h7fff, 16'h7fff, 1'b1);
    while (pending_words.size() < 350) begin
      case ($urandom_range(0, 9))
        0: add_run($urandom_range(0, 64), 64 + $urandom_range(1, 4));
        1: begin
          na = $urandom_range(0, 63);
          add_run(na, 64 - na);
        end
        default: add_run($urandom_range(0, 8), $urandom_range(1, 8));
      endcase
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    logic next_push;
    in_word_t w;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) convolve_word(mode, re, im, last);
      if (push && full) begin
        next_push = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        next_push = 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        mode <= w.mode; re <= w.re; im <= w.im; last <= w.last;
        next_push = 1'b1;
        if (pending_words.size() > 60 && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 13);
      end else begin
        next_push = 1'b0;
      end
      push <= next_push;
    end
  end

  always @(posedge clk) begin
    conv_res_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_conv.size() == 0) begin
          if (errors < 10) $display("unexpected result word: index %0d", index);
          errors++;
        end else begin
          e = expected_conv.pop_front();
          if (index !== e.index || res_re !== e.res_re || res_im !== e.res_im ||
              too_long !== e.too_long || end_res !== e.end_res) begin
            if (errors < 10)
              $display("mismatch: exp %0d %0d %0d %b %b, got %0d %0d %0d %b %b",
                       e.index, e.res_re, e.res_im, e.too_long, e.end_res,
                       index, res_re, res_im, too_long, end_res);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (pending_words.size() > 60 && $urandom_range(0, 15) == 0)
          recv_gap = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    while (pending_words.size() > 0 || push || expected_conv.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_conv.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/fftc_pkg.sv
hw/rtl/fftc_ram.sv
hw/rtl/fftc_queue.sv
hw/rtl/fftc_engine.sv
hw/rtl/fft_convolution.sv
tb/tb_top.sv
